>>> rtl/ssed_pkg.sv
// Shared types and constants of the solenoid stroke-end detector.
// Used by the channel interfaces, the serial divider, the core and its checker.
`default_nettype none
package ssed_pkg;

    // field widths
    localparam int REQ_W      = 2;
    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 16;
    localparam int VBAT_W     = 16;
    localparam int MODE_W     = 2;
    localparam int ETC_W      = 20;
    localparam int LIM_W      = 16;
    localparam int LEVEL_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // rounded battery volts, clamped stroke time, volts x time product
    localparam int VOLT_W  = 9;
    localparam int CLAMP_W = ETC_W + 1;
    localparam int PROD_W  = CLAMP_W + VOLT_W;

    // slope test: numerator = dI * 1000 * 256, divided by dt
    localparam int NUM_W = 34;
    localparam int S29_W = NUM_W + 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EXTEND    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISCHARGE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RETRACT   = 2'd3;

    // pusher modes
    localparam logic [MODE_W-1:0] MODE_PASSIVE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXTEND    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISCHARGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_CONST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RET_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RET_WINDOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_JUMP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RET_LEVEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RET_JUMP    = 3'd7;

    // configuration reset values
    localparam logic [ETC_W-1:0]   EXT_CONST_RST   = 20'd460000;
    localparam logic [LIM_W-1:0]   RET_TIMEOUT_RST = 16'd20000;
    localparam logic [LIM_W-1:0]   RET_WINDOW_RST  = 16'd10000;
    localparam logic [LEVEL_W-1:0] EXT_LEVEL_RST   = 15'd20000;
    localparam logic [LIM_W-1:0]   EXT_JUMP_RST    = 16'd15000;
    localparam logic [LEVEL_W-1:0] RET_LEVEL_RST   = 15'd15000;
    localparam logic [LIM_W-1:0]   RET_JUMP_RST    = 16'd10000;

    // arithmetic constants
    localparam logic [VBAT_W:0]    VBAT_ROUND  = 17'd128;
    localparam logic [9:0]         SLOPE_GAIN  = 10'd1000;
    localparam logic [4:0]         LIMIT_DIV   = 5'd29;
    localparam logic [TIME_W-1:0]  CLOSE_DT    = 32'd200;
    // late window start when the timeout saturates at all ones: 2/3 of 2^32-1
    localparam logic [TIME_W-1:0]  NOVOLT_LATE = 32'hAAAAAAAA;
    localparam logic [CLAMP_W-1:0] TIME_SAT    = 21'h100000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

>>> rtl/ssed_req_if.sv
// Request channel of the stroke-end detector: valid/ready plus request fields.
// Depends on ssed_pkg for field widths.
`default_nettype none
interface ssed_req_if;
    logic                               valid;
    logic                               ready;
    logic [ssed_pkg::REQ_W-1:0]         req_type;
    logic [ssed_pkg::TIME_W-1:0]        time_us;
    logic signed [ssed_pkg::SAMPLE_W-1:0] solenoid_current;
    logic signed [ssed_pkg::SAMPLE_W-1:0] accel_y;
    logic [ssed_pkg::VBAT_W-1:0]        battery_voltage;

    modport source (
        output valid, req_type, time_us, solenoid_current, accel_y, battery_voltage,
        input  ready
    );
    modport sink (
        input  valid, req_type, time_us, solenoid_current, accel_y, battery_voltage,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/ssed_res_if.sv
// Result channel of the stroke-end detector: valid/ready plus drive and status.
// Depends on ssed_pkg for field widths.
`default_nettype none
interface ssed_res_if;
    logic                        valid;
    logic                        ready;
    logic                        drive_in1;
    logic                        drive_in2;
    logic [ssed_pkg::MODE_W-1:0] pusher_mode;
    logic                        fully_extended;
    logic                        fully_retracted;

    modport source (
        output valid, drive_in1, drive_in2, pusher_mode, fully_extended, fully_retracted,
        input  ready
    );
    modport sink (
        input  valid, drive_in1, drive_in2, pusher_mode, fully_extended, fully_retracted,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/solenoid_stroke_end_detector_core.sv
// Solenoid pusher stroke-end detector, top level.
// Depends on ssed_pkg, ssed_req_if, ssed_res_if and ssed_div.
//
// Usage:
//  - i_req (valid/ready) carries one request: a sample tick with time, current,
//    accel and battery voltage, or an extend / discharge / retract command.
//  - o_res (valid/ready) returns one result per request: H-bridge levels, the
//    pusher mode and the fully-extended / fully-retracted flags after it.
//  - i_cfg_we/i_cfg_idx/i_cfg_data write the eight settings; write only while
//    no request is in flight.
// Path from request accept to result valid:
//  - commands, passive and discharging ticks: ST_EVAL, then ST_DONE.
//  - extending ticks: ST_EVAL, ST_MUL, ST_DONE; the bit-serial volts x time multiply
//    by the 9-bit volts tests the timeout and the start of the late window.
//  - late-window ticks that reach the current slope test: ST_DIV follows ST_MUL;
//    the bit-serial divider forms the slope.
//  One request is in work at a time; i_req.ready returns the cycle after the
//  result loads.
// Reset: settings take their defaults, mode passive, retracted flag set,
//  timers and sample history cleared, no result pending.
// Stall: a finished result waits in the output register; the next request is
//  still taken and worked, then held until the output register frees.
`default_nettype none
module solenoid_stroke_end_detector_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    ssed_req_if.sink                              i_req,
    ssed_res_if.source                            o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [ssed_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ssed_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int T_W   = ssed_pkg::TIME_W;
    localparam int S_W   = ssed_pkg::SAMPLE_W;
    localparam int P_W   = ssed_pkg::PROD_W;
    localparam int V_W   = ssed_pkg::VOLT_W;
    localparam int C_W   = ssed_pkg::CLAMP_W;
    localparam int E_W   = ssed_pkg::ETC_W;
    localparam int MCNT_W = $clog2(V_W + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    // settings
    logic                              r_enable;
    logic [E_W-1:0]                    r_etc;
    logic [ssed_pkg::LIM_W-1:0]        r_rto, r_rwin, r_aej, r_arj;
    logic [ssed_pkg::LEVEL_W-1:0]      r_ael, r_arl;

    // pusher state
    t_state                            r_state, n_state;
    logic [ssed_pkg::MODE_W-1:0]       r_mode, n_mode;
    logic                              r_ext_flag, n_ext_flag;
    logic                              r_ret_flag, n_ret_flag;
    logic [T_W-1:0]                    r_ext_start, n_ext_start;
    logic [T_W-1:0]                    r_ret_start, n_ret_start;
    logic signed [S_W-1:0]             r_ch0, r_ch1;
    logic [T_W-1:0]                    r_th0, r_th1;
    logic signed [S_W-1:0]             r_prev_acc;
    logic                              do_shift;

    // latched request
    logic [ssed_pkg::REQ_W-1:0]        r_req;
    logic [T_W-1:0]                    r_now;
    logic signed [S_W-1:0]             r_cur, r_acc;
    logic [ssed_pkg::VBAT_W-1:0]       r_vbat;

    // serial multiplier: volts x (t+1) and volts x ceil-window bound
    logic [MCNT_W-1:0]                 r_mul_cnt, n_mul_cnt;
    logic [V_W-1:0]                    r_mplier, n_mplier;
    logic [P_W-1:0]                    r_mcand_a, n_mcand_a, r_mcand_b, n_mcand_b;
    logic [P_W-1:0]                    r_prod_a, n_prod_a, r_prod_b, n_prod_b;

    // output register
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_in1, r_out_in2, r_out_ext, r_out_ret;
    logic [ssed_pkg::MODE_W-1:0]       r_out_mode;
    logic                              load_out;

    // datapath terms
    logic                              in_ready, accept;
    logic [ssed_pkg::VBAT_W:0]         vsum;
    logic [V_W-1:0]                    volts;
    logic                              vzero;
    logic [T_W-1:0]                    t_ext, t_ret, dt;
    logic                              dt_close;
    logic                              big_t;
    logic [C_W:0]                      m_full;
    logic [C_W-1:0]                    a_sat, m_sat;
    logic                              ext_hit, late;
    logic signed [S_W:0]               cur_diff, acc_x, prev_x, acc_diff;
    logic signed [S_W:0]               ael_x, aej_x, arl_x, arj_x;
    logic                              diff_pos, spike, dip;
    logic [ssed_pkg::NUM_W-1:0]        slope_num;
    logic [ssed_pkg::S29_W-1:0]        quo29;
    logic                              slope_hit;

    // divider link
    logic                              div_start;
    ssed_pkg::t_div_stat               div_stat;
    logic [ssed_pkg::NUM_W-1:0]        div_quo;

    ssed_div #(
        .P_NUM_W (ssed_pkg::NUM_W),
        .P_DEN_W (ssed_pkg::TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (slope_num),
        .i_den   (dt),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign in_ready    = r_state == ST_IDLE;
    assign i_req.ready = in_ready;
    assign accept      = i_req.valid && in_ready;

    // ---------------------------------------------------------------
    // Tick arithmetic on the latched request
    // ---------------------------------------------------------------
    always_comb begin
        vsum  = {1'b0, r_vbat} + ssed_pkg::VBAT_ROUND;
        volts = vsum[ssed_pkg::VBAT_W:8];
        vzero = volts == '0;

        t_ext = r_now - r_ext_start;
        t_ret = r_now - r_ret_start;

        // T = etc / volts never exceeds 2^20 - 1, so times past 2^20 clamp
        // without changing either compare.
        //   t >= T           <=> etc < volts * (t + 1)
        //   t >= floor(2T/3) <=> etc < volts * floor((3t + 4) / 2)
        big_t  = |t_ext[T_W-1:E_W];
        a_sat  = big_t ? ssed_pkg::TIME_SAT : ({1'b0, t_ext[E_W-1:0]} + C_W'(1));
        m_full = ({2'b00, t_ext[E_W-1:0]} + {1'b0, t_ext[E_W-1:0], 1'b0}
                  + (C_W + 1)'(4));
        m_sat  = (big_t || (m_full[C_W:1] > ssed_pkg::TIME_SAT))
                 ? ssed_pkg::TIME_SAT : m_full[C_W:1];

        ext_hit = vzero ? (t_ext == '1) : (P_W'(r_etc) < r_prod_a);
        late    = vzero ? (t_ext >= ssed_pkg::NOVOLT_LATE) : (P_W'(r_etc) < r_prod_b);

        // signed dt; negative counts as close
        dt       = r_now - r_th1;
        dt_close = dt[T_W-1] || (dt < ssed_pkg::CLOSE_DT);

        cur_diff = {r_cur[S_W-1], r_cur} - {r_ch1[S_W-1], r_ch1};
        diff_pos = !cur_diff[S_W] && (cur_diff != '0);
        slope_num = {26'(cur_diff[S_W-1:0]) * 26'(ssed_pkg::SLOPE_GAIN), 8'b0};

        acc_x    = {r_acc[S_W-1], r_acc};
        prev_x   = {r_prev_acc[S_W-1], r_prev_acc};
        acc_diff = acc_x - prev_x;
        ael_x    = {2'b00, r_ael};
        aej_x    = {1'b0, r_aej};
        arl_x    = {2'b00, r_arl};
        arj_x    = {1'b0, r_arj};
        spike    = (acc_x > ael_x) && (acc_diff > aej_x);
        dip      = (acc_x < -arl_x) && (acc_diff < -arj_x);

        // slope > floor(vbat*256/29)  <=>  29 * floor(num/dt) > vbat*256
        quo29     = ssed_pkg::S29_W'(div_quo) * ssed_pkg::S29_W'(ssed_pkg::LIMIT_DIV);
        slope_hit = quo29 > ssed_pkg::S29_W'({r_vbat, 8'b0});
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_ext_flag  = r_ext_flag;
        n_ret_flag  = r_ret_flag;
        n_ext_start = r_ext_start;
        n_ret_start = r_ret_start;
        n_mul_cnt   = r_mul_cnt;
        n_mplier    = r_mplier;
        n_mcand_a   = r_mcand_a;
        n_mcand_b   = r_mcand_b;
        n_prod_a    = r_prod_a;
        n_prod_b    = r_prod_b;
        do_shift    = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_req != ssed_pkg::REQ_TICK) begin
                    if (r_enable) begin
                        unique case (r_req)
                            ssed_pkg::REQ_EXTEND: begin
                                n_ret_flag = 1'b0;
                                if (r_mode != ssed_pkg::MODE_EXTEND) begin
                                    n_ext_start = r_now;
                                end
                                n_mode = ssed_pkg::MODE_EXTEND;
                            end
                            ssed_pkg::REQ_DISCHARGE: begin
                                n_ext_flag = 1'b0;
                                if (r_mode != ssed_pkg::MODE_DISCHARGE) begin
                                    n_ret_start = r_now;
                                end
                                n_mode = ssed_pkg::MODE_DISCHARGE;
                            end
                            default: begin
                                n_ext_flag = 1'b0;
                                if (r_mode == ssed_pkg::MODE_EXTEND) begin
                                    n_ret_start = r_now;
                                end
                                n_mode = ssed_pkg::MODE_PASSIVE;
                            end
                        endcase
                    end
                    n_state = ST_DONE;
                end else if (r_mode == ssed_pkg::MODE_EXTEND) begin
                    n_mul_cnt = MCNT_W'(V_W);
                    n_mplier  = volts;
                    n_mcand_a = P_W'(a_sat);
                    n_mcand_b = P_W'(m_sat);
                    n_prod_a  = '0;
                    n_prod_b  = '0;
                    n_state   = ST_MUL;
                end else begin
                    if (r_mode == ssed_pkg::MODE_PASSIVE) begin
                        if (t_ret >= T_W'(r_rto)) begin
                            n_ret_flag = 1'b1;
                        end else if ((t_ret >= T_W'(r_rwin)) && dip) begin
                            n_ret_flag = 1'b1;
                        end
                    end
                    do_shift = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_MUL: begin
                if (r_mul_cnt != '0) begin
                    if (r_mplier[0]) begin
                        n_prod_a = r_prod_a + r_mcand_a;
                        n_prod_b = r_prod_b + r_mcand_b;
                    end
                    n_mcand_a = r_mcand_a << 1;
                    n_mcand_b = r_mcand_b << 1;
                    n_mplier  = r_mplier >> 1;
                    n_mul_cnt = r_mul_cnt - 1'b1;
                end else if (ext_hit) begin
                    n_ext_flag = 1'b1;
                    do_shift   = 1'b1;
                    n_state    = ST_DONE;
                end else if (late) begin
                    if (dt_close) begin
                        // too close to the older recorded tick: no change at all
                        n_state = ST_DONE;
                    end else if (spike) begin
                        n_ext_flag = 1'b1;
                        do_shift   = 1'b1;
                        n_state    = ST_DONE;
                    end else if (!diff_pos) begin
                        do_shift = 1'b1;
                        n_state  = ST_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end else begin
                    do_shift = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (slope_hit) begin
                        n_ext_flag = 1'b1;
                    end
                    do_shift = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control, settings and pusher state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b0;
            r_etc       <= ssed_pkg::EXT_CONST_RST;
            r_rto       <= ssed_pkg::RET_TIMEOUT_RST;
            r_rwin      <= ssed_pkg::RET_WINDOW_RST;
            r_ael       <= ssed_pkg::EXT_LEVEL_RST;
            r_aej       <= ssed_pkg::EXT_JUMP_RST;
            r_arl       <= ssed_pkg::RET_LEVEL_RST;
            r_arj       <= ssed_pkg::RET_JUMP_RST;
            r_mode      <= ssed_pkg::MODE_PASSIVE;
            r_ext_flag  <= 1'b0;
            r_ret_flag  <= 1'b1;
            r_ext_start <= '0;
            r_ret_start <= '0;
            r_ch0       <= '0;
            r_ch1       <= '0;
            r_th0       <= '0;
            r_th1       <= '0;
            r_prev_acc  <= '0;
            r_mul_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_ext_flag  <= n_ext_flag;
            r_ret_flag  <= n_ret_flag;
            r_ext_start <= n_ext_start;
            r_ret_start <= n_ret_start;
            r_mul_cnt   <= n_mul_cnt;
            r_out_valid <= n_out_valid;
            if (do_shift) begin
                r_ch1      <= r_ch0;
                r_ch0      <= r_cur;
                r_th1      <= r_th0;
                r_th0      <= r_now;
                r_prev_acc <= r_acc;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ssed_pkg::CFG_ENABLE:      r_enable <= i_cfg_data[0];
                    ssed_pkg::CFG_EXT_CONST:   r_etc    <= i_cfg_data[E_W-1:0];
                    ssed_pkg::CFG_RET_TIMEOUT: r_rto    <= i_cfg_data[ssed_pkg::LIM_W-1:0];
                    ssed_pkg::CFG_RET_WINDOW:  r_rwin   <= i_cfg_data[ssed_pkg::LIM_W-1:0];
                    ssed_pkg::CFG_EXT_LEVEL:   r_ael    <= i_cfg_data[ssed_pkg::LEVEL_W-1:0];
                    ssed_pkg::CFG_EXT_JUMP:    r_aej    <= i_cfg_data[ssed_pkg::LIM_W-1:0];
                    ssed_pkg::CFG_RET_LEVEL:   r_arl    <= i_cfg_data[ssed_pkg::LEVEL_W-1:0];
                    ssed_pkg::CFG_RET_JUMP:    r_arj    <= i_cfg_data[ssed_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload: request latch, multiplier datapath, result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req.req_type;
            r_now  <= i_req.time_us;
            r_cur  <= i_req.solenoid_current;
            r_acc  <= i_req.accel_y;
            r_vbat <= i_req.battery_voltage;
        end
        r_mplier  <= n_mplier;
        r_mcand_a <= n_mcand_a;
        r_mcand_b <= n_mcand_b;
        r_prod_a  <= n_prod_a;
        r_prod_b  <= n_prod_b;
        if (load_out) begin
            r_out_in1  <= r_mode == ssed_pkg::MODE_DISCHARGE;
            r_out_in2  <= r_mode == ssed_pkg::MODE_EXTEND;
            r_out_mode <= r_mode;
            r_out_ext  <= r_ext_flag;
            r_out_ret  <= r_ret_flag;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.drive_in1       = r_out_in1;
    assign o_res.drive_in2       = r_out_in2;
    assign o_res.pusher_mode     = r_out_mode;
    assign o_res.fully_extended  = r_out_ext;
    assign o_res.fully_retracted = r_out_ret;
endmodule
`default_nettype wire

>>> rtl/ssed_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ssed_pkg (t_div_stat, default widths).
`default_nettype none
module ssed_div #(
    parameter int P_NUM_W = ssed_pkg::NUM_W,
    parameter int P_DEN_W = ssed_pkg::TIME_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [P_NUM_W-1:0]    i_num,
    input  wire logic [P_DEN_W-1:0]    i_den,
    output ssed_pkg::t_div_stat        o_stat,
    output logic      [P_NUM_W-1:0]    o_quo
);
    localparam int CNT_W = $clog2(P_NUM_W + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [P_NUM_W-1:0] r_quo;
    logic [P_DEN_W-1:0] r_rem;
    logic [P_DEN_W-1:0] r_den;

    logic [P_DEN_W:0]   rem_sh;
    logic               q_bit;
    logic [P_DEN_W-1:0] n_rem;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem_sh = {r_rem, r_quo[P_NUM_W-1]};
        q_bit  = rem_sh >= {1'b0, r_den};
        n_rem  = q_bit ? P_DEN_W'(rem_sh - {1'b0, r_den}) : P_DEN_W'(rem_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(P_NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[P_NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_cnt != '0;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
endmodule
`default_nettype wire

>>> rtl/ssed_checker.sv
// Port-level checks for the stroke-end detector core, bound to the top level.
// Depends on ssed_pkg and solenoid_stroke_end_detector_core.
`default_nettype none
module ssed_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        i_drive_in1,
    input wire logic                        i_drive_in2,
    input wire logic [ssed_pkg::MODE_W-1:0] i_pusher_mode,
    input wire logic                        i_fully_extended,
    input wire logic                        i_fully_retracted
);
    // bridge levels follow the reported mode
    a_drive_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_drive_in1 == (i_pusher_mode == ssed_pkg::MODE_DISCHARGE))
                     && (i_drive_in2 == (i_pusher_mode == ssed_pkg::MODE_EXTEND)))
        else $error("drive levels disagree with pusher mode");

    // extension is only ever reported while extending
    a_ext_only_extending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fully_extended |-> i_pusher_mode == ssed_pkg::MODE_EXTEND)
        else $error("fully extended outside extend mode");

    // one request in work at a time
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while another is in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pusher_mode)
            && $stable(i_fully_extended) && $stable(i_fully_retracted))
        else $error("result changed while stalled");
endmodule

bind solenoid_stroke_end_detector_core ssed_checker u_ssed_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_drive_in1       (o_res.drive_in1),
    .i_drive_in2       (o_res.drive_in2),
    .i_pusher_mode     (o_res.pusher_mode),
    .i_fully_extended  (o_res.fully_extended),
    .i_fully_retracted (o_res.fully_retracted)
);
`default_nettype wire
